// File: sv/ffd_pkg.sv
package ffd_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_A  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_B  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_C  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_D  = 3'd5;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] type_code_a;
        logic [7:0] type_code_b;
        logic [7:0] type_code_c;
        logic [7:0] type_code_d;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  time_tag;
        logic [7:0]  kind_code;
        logic [63:0] payload_head;
        logic [31:0] payload_tail;
    } frame_t;

endpackage

// File: sv/ffd_front.sv
module ffd_front #(
    parameter int FRAME_BYTES = ffd_pkg::FRAME_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffd_pkg::cfg_t   cfg,
    input  logic            rx_valid,
    output logic            rx_ready,
    input  logic [7:0]      rx_byte,
    input  logic            queue_full,
    output logic            push,
    output ffd_pkg::frame_t frame
);
    import ffd_pkg::*;

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W  = $clog2(FRAME_BYTES);

    logic [7:0]        win_reg  [FRAME_BYTES];
    logic [7:0]        win_next [FRAME_BYTES];
    logic [7:0]        cur      [FRAME_BYTES];
    logic [7:0]        shifted  [FRAME_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [IDX_W-1:0]  last;
    logic [FILL_W-1:0] src;
    logic              rx_fire;
    logic              kind_ok;
    logic              win_ok;

    assign rx_ready = !queue_full;
    assign rx_fire  = rx_valid && rx_ready;

    // window as it stands with the incoming byte in the top slot
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            cur[i] = (i == FRAME_BYTES - 1) ? rx_byte : win_reg[i];
        end
    end

    assign kind_ok = (cur[FRAME_BYTES-2] == cfg.type_code_a) ||
                     (cur[FRAME_BYTES-2] == cfg.type_code_b) ||
                     (cur[FRAME_BYTES-2] == cfg.type_code_c) ||
                     (cur[FRAME_BYTES-2] == cfg.type_code_d);
    assign win_ok  = (cur[FRAME_BYTES-1] == cfg.end_marker) && kind_ok;

    // last start marker above index 0
    always_comb
    begin
        last = '0;
        for (int i = 1; i < FRAME_BYTES; i++)
        begin
            if (cur[i] == cfg.start_marker)
            begin
                last = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            src = FILL_W'(i) + FILL_W'(last);
            if (src < FILL_W'(FRAME_BYTES))
            begin
                shifted[i] = cur[src[IDX_W-1:0]];
            end
            else
            begin
                shifted[i] = cur[i];
            end
        end
    end

    always_comb
    begin
        frame.time_tag  = cur[1];
        frame.kind_code = cur[FRAME_BYTES-2];
        for (int i = 0; i < 8; i++)
        begin
            frame.payload_head[63-8*i -: 8] = cur[2+i];
        end
        for (int i = 0; i < 4; i++)
        begin
            frame.payload_tail[31-8*i -: 8] = cur[10+i];
        end
    end

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        push      = 1'b0;
        if (rx_fire)
        begin
            if (fill_reg == '0)
            begin
                if (rx_byte == cfg.start_marker)
                begin
                    win_next[0] = rx_byte;
                    fill_next   = FILL_W'(1);
                end
            end
            else if (fill_reg >= FILL_W'(FRAME_BYTES))
            begin
                fill_next = '0;
            end
            else if (fill_reg == FILL_W'(FRAME_BYTES - 1))
            begin
                if (win_ok)
                begin
                    push      = 1'b1;
                    fill_next = '0;
                end
                else if (last == '0)
                begin
                    fill_next = '0;
                end
                else
                begin
                    win_next  = shifted;
                    fill_next = FILL_W'(FRAME_BYTES) - FILL_W'(last);
                end
            end
            else
            begin
                win_next[fill_reg[IDX_W-1:0]] = rx_byte;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(FRAME_BYTES))
        else $error("window fill count out of range");

    a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && fill_reg == '0 && rx_byte != cfg.start_marker) |=> fill_reg == '0)
        else $error("non-marker byte opened a window");

    a_push_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> fill_reg == '0)
        else $error("valid frame did not return to hunting");

endmodule

// File: sv/ffd_queue.sv
module ffd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ffd_pkg::frame_t push_frame,
    output logic            full,
    output logic            res_valid,
    input  logic            res_ready,
    output ffd_pkg::frame_t head
);
    import ffd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign res_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("frame pushed into full queue");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(head)))
        else $error("stalled transaction changed");

endmodule

// File: sv/fixed_frame_deframer_resync.sv
// a frame is offered on res_valid in the cycle after its last byte is taken
// throughput: one rx byte per cycle while the result queue is not full, set by the combinational window check and shift
// rx_ready drops only while both entries of the two-deep result queue are taken
// reset: async active low; hunting, queue empty, control and config registers zero
// window contents are not reset and are only read once written
module fixed_frame_deframer_resync #(
    parameter int FRAME_BYTES = ffd_pkg::FRAME_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           rx_valid,
    output logic                           rx_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [7:0]                     time_tag,
    output logic [7:0]                     kind_code,
    output logic [63:0]                    payload_head,
    output logic [31:0]                    payload_tail
);
    import ffd_pkg::*;

    cfg_t   cfg_reg;
    logic   queue_full;
    logic   push;
    frame_t frame;
    frame_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_MARKER: cfg_reg.start_marker <= cfg_data;
                REG_END_MARKER:   cfg_reg.end_marker   <= cfg_data;
                REG_TYPE_CODE_A:  cfg_reg.type_code_a  <= cfg_data;
                REG_TYPE_CODE_B:  cfg_reg.type_code_b  <= cfg_data;
                REG_TYPE_CODE_C:  cfg_reg.type_code_c  <= cfg_data;
                REG_TYPE_CODE_D:  cfg_reg.type_code_d  <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    ffd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .frame      (frame)
    );

    ffd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (frame),
        .full       (queue_full),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .head       (head)
    );

    assign time_tag     = head.time_tag;
    assign kind_code    = head.kind_code;
    assign payload_head = head.payload_head;
    assign payload_tail = head.payload_tail;

endmodule

// File: tb/sv/fixed_frame_deframer_resync_tb.sv
`timescale 1ns / 1ps

module fixed_frame_deframer_resync_tb;

    import ffd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int N_SETTINGS = 7;
    localparam int BYTES_PER_SETTING = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] OPENING_BYTES [25] = '{
        8'h00, 8'hFF, 8'h5A,
        8'hA5, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h04, 8'h5A,
        8'hA5, 8'h00, 8'h01, 8'h02, 8'h03, 8'hA5
    };

    class frame_tracker;
        logic [7:0] start_marker = 8'h00;
        logic [7:0] end_marker = 8'h00;
        logic [7:0] type_codes [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
        logic [7:0] win [FRAME_BYTES];
        int unsigned fill = 0;
        frame_t frames_due [$];
        int errors = 0;

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
            case (idx)
                REG_START_MARKER: start_marker = v;
                REG_END_MARKER:   end_marker = v;
                REG_TYPE_CODE_A:  type_codes[0] = v;
                REG_TYPE_CODE_B:  type_codes[1] = v;
                REG_TYPE_CODE_C:  type_codes[2] = v;
                REG_TYPE_CODE_D:  type_codes[3] = v;
                default: ;
            endcase
        endfunction

        function bit window_ok();
            bit kind_hit;
            kind_hit = 1'b0;
            foreach (type_codes[i])
                if (win[FRAME_BYTES-2] == type_codes[i])
                    kind_hit = 1'b1;
            return (win[FRAME_BYTES-1] == end_marker) && kind_hit;
        endfunction

        function void take_byte(input logic [7:0] b);
            int unsigned last;
            frame_t f;
            if (fill == 0)
            begin
                if (b == start_marker)
                begin
                    win[0] = b;
                    fill = 1;
                end
                return;
            end
            win[fill] = b;
            fill++;
            if (fill < FRAME_BYTES)
                return;
            if (!window_ok())
            begin
                // slide down to the last start marker past byte 0
                last = 0;
                for (int i = 1; i < FRAME_BYTES; i++)
                    if (win[i] == start_marker)
                        last = i;
                for (int i = 0; i + last < FRAME_BYTES; i++)
                    win[i] = win[i + last];
                fill = (last == 0) ? 0 : FRAME_BYTES - last;
                return;
            end
            f.time_tag = win[1];
            f.kind_code = win[FRAME_BYTES-2];
            for (int i = 2; i < 10; i++)
                f.payload_head = {f.payload_head[55:0], win[i]};
            for (int i = 10; i < 14; i++)
                f.payload_tail = {f.payload_tail[23:0], win[i]};
            frames_due.push_back(f);
            fill = 0;
        endfunction

        function void flag(input string what, input logic [63:0] want, input logic [63:0] got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch %s: expected %h got %h", what, want, got);
        endfunction

        function void match_frame(input frame_t got);
            frame_t want;
            if (frames_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("frame with none pending: %h", got);
                return;
            end
            want = frames_due.pop_front();
            if (got.time_tag !== want.time_tag)
                flag("time_tag", 64'(want.time_tag), 64'(got.time_tag));
            if (got.kind_code !== want.kind_code)
                flag("kind_code", 64'(want.kind_code), 64'(got.kind_code));
            if (got.payload_head !== want.payload_head)
                flag("payload_head", want.payload_head, got.payload_head);
            if (got.payload_tail !== want.payload_tail)
                flag("payload_tail", 64'(want.payload_tail), 64'(got.payload_tail));
        endfunction

        function void flush_leftover();
            if (frames_due.size() != 0)
            begin
                errors += frames_due.size();
                $display("%0d frames never arrived", frames_due.size());
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_START_MARKER;
    logic [7:0] cfg_data = 8'h00;
    logic rx_valid = 1'b0;
    logic rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [7:0] time_tag;
    logic [7:0] kind_code;
    logic [63:0] payload_head;
    logic [31:0] payload_tail;

    frame_tracker tracker = new;
    int unsigned tx_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit hold_req = 1'b0;

    fixed_frame_deframer_resync i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .time_tag     (time_tag),
        .kind_code    (kind_code),
        .payload_head (payload_head),
        .payload_tail (payload_tail)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fixed_frame_deframer_resync_tb: errors");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
            if (rx_valid && rx_ready)
                tracker.take_byte(rx_byte);
            if (res_valid && res_ready)
                tracker.match_frame({time_tag, kind_code, payload_head, payload_tail});
        end
    end

    // result side, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            res_ready = 1'b0;
            hold_left--;
        end
        else
            res_ready = ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            rx_valid = 1'b0;
            @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte = b;
        do
            @(posedge clk);
        while (!rx_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_frame(input bit broken);
        logic [7:0] fr [FRAME_BYTES];
        fr[0] = tracker.start_marker;
        for (int i = 1; i < FRAME_BYTES - 2; i++)
            fr[i] = 8'($urandom_range(255));
        fr[FRAME_BYTES-2] = tracker.type_codes[$urandom_range(3)];
        fr[FRAME_BYTES-1] = tracker.end_marker;
        if (broken)
        begin
            case ($urandom_range(2))
                0: fr[FRAME_BYTES-1] = 8'($urandom_range(255));
                1: fr[FRAME_BYTES-2] = 8'($urandom_range(255));
                default: fr[$urandom_range(FRAME_BYTES - 1, 1)] = tracker.start_marker;
            endcase
        end
        foreach (fr[i])
            send_byte(fr[i]);
    endtask

    task automatic random_burst();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        if (pick < 55)
            send_frame(1'b0);
        else if (pick < 70)
            send_frame(1'b1);
        else if (pick < 85)
        begin
            // false start with stray markers, then a good frame to resync onto
            send_byte(tracker.start_marker);
            n = $urandom_range(14, 1);
            repeat (n)
                send_byte(($urandom_range(2) == 0) ? tracker.start_marker
                                                   : 8'($urandom_range(255)));
            send_frame(1'b0);
        end
        else
        begin
            n = $urandom_range(6, 1);
            repeat (n)
                send_byte(($urandom_range(3) == 0) ? tracker.start_marker
                                                   : 8'($urandom_range(255)));
        end
    endtask

    task automatic load_setting(input int p);
        logic [7:0] s;
        logic [7:0] e;
        logic [7:0] codes [4];
        s = 8'($urandom_range(255));
        e = 8'($urandom_range(255));
        foreach (codes[i])
            codes[i] = 8'($urandom_range(255));
        case (p)
            0:
            begin
                s = 8'hA5;
                e = 8'h5A;
                codes = '{8'h01, 8'h02, 8'h03, 8'h04};
            end
            1:
            begin
                s = 8'h00;
                e = 8'h00;
                codes = '{8'h00, 8'h00, 8'h00, 8'h00};
            end
            2:
            begin
                s = 8'h00;
                e = 8'hFF;
                codes[0] = 8'h00;
                codes[1] = 8'hFF;
            end
            3:
            begin
                s = 8'hFF;
                e = 8'h00;
                codes = '{8'h80, 8'h80, 8'h80, 8'h80};
            end
            4:
            begin
                e = s;
                codes[0] = s;
            end
            default: ;
        endcase
        cfg_write(REG_SPARE_6, 8'($urandom_range(255)));
        cfg_write(REG_START_MARKER, s);
        cfg_write(REG_END_MARKER, e);
        cfg_write(REG_TYPE_CODE_A, codes[0]);
        cfg_write(REG_TYPE_CODE_B, codes[1]);
        cfg_write(REG_TYPE_CODE_C, codes[2]);
        cfg_write(REG_TYPE_CODE_D, codes[3]);
        cfg_write(REG_SPARE_7, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        rx_valid = 1'b0;
        while (tracker.frames_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned phase_end;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int p = 0; p < N_SETTINGS; p++)
        begin
            if (p <= 2)
            begin
                tx_idle_pct = 30;
                rcv_idle_pct = 55;
            end
            else if (p <= 4)
            begin
                tx_idle_pct = 55;
                rcv_idle_pct = 30;
            end
            else
            begin
                tx_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            load_setting(p);
            if (p == 0)
                foreach (OPENING_BYTES[i])
                    send_byte(OPENING_BYTES[i]);
            if (p == 5)
            begin
                // results back up until the input stalls
                hold_req = 1'b1;
                repeat (5)
                    send_frame(1'b0);
            end
            phase_end = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < phase_end)
                random_burst();
            drain();
        end
        tracker.flush_leftover();
        if (tracker.errors == 0)
            $display("fixed_frame_deframer_resync_tb: clean");
        else
            $display("fixed_frame_deframer_resync_tb: errors");
        $finish;
    end

endmodule
